// File: sv/bst_pkg.sv
`default_nettype none
package bst_pkg;

  // field widths of one item
  localparam int CMD_W     = 2;
  localparam int ELEM_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  // stream widths, packed from bit 0 and padded to whole bytes
  localparam int S_TDATA_W = ((CMD_W + ELEM_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((STATUS_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_e_t;

  // controller to datapath
  typedef struct packed {
    logic      load;      // capture the input item, restart the index
    logic      idx_inc;   // step the index
    logic      rd_en;     // read the table
    logic      rd_next;   // read at index plus one instead of index
    logic      shift_wr;  // write the read data back one place lower
    logic      finish;    // update count, append, load the result
    logic      ins_wr;    // append the element at the count
    cnt_op_e_t cnt_op;
    status_e_t status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e_t cmd;
    logic   idx_end;   // index has reached the count
    logic   idx1_end;  // index plus one has reached the count
    logic   full;      // count equals capacity
    logic   match;     // read data equals the element
    logic   out_free;  // result register can take a new item
  } dp_sts_t;

endpackage
`default_nettype wire

// File: sv/bst_ram.sv
`default_nettype none
module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sv/bst_datapath.sv
`default_nettype none
module bst_datapath #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  input  wire logic [bst_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [bst_pkg::M_TDATA_W-1:0] m_tdata,
  input  wire bst_pkg::dp_cmd_t              dp_cmd,
  output bst_pkg::dp_sts_t                   dp_sts
);
  import bst_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  cmd_e_t            cmd_q;
  logic [ELEM_W-1:0] elem;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_next;
  // index runs up to the count, so it is as wide as the count
  logic [CW-1:0]     idx;
  logic [CW-1:0]     idx_ext;
  status_e_t         out_status;
  logic [COUNT_W-1:0] out_count;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ELEM_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ELEM_W-1:0] ram_rdata;

  assign idx_ext = CW'(idx);

  // member table
  bst_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (dp_cmd.rd_en),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // write port: shift a member down, or append at the end
  assign ram_we    = dp_cmd.shift_wr || (dp_cmd.finish && dp_cmd.ins_wr);
  assign ram_waddr = dp_cmd.shift_wr ? AW'(idx) : AW'(cnt);
  assign ram_wdata = dp_cmd.shift_wr ? ram_rdata : elem;
  assign ram_raddr = dp_cmd.rd_next ? AW'(idx + CW'(1)) : AW'(idx);

  // count update at the end of an item
  always_comb begin
    case (dp_cmd.cnt_op)
      CNT_INC: cnt_next = cnt + CW'(1);
      CNT_DEC: cnt_next = cnt - CW'(1);
      CNT_CLR: cnt_next = '0;
      default: cnt_next = cnt;
    endcase
  end

  // item capture, index, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (dp_cmd.load) begin
        idx <= '0;
      end else if (dp_cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (dp_cmd.finish) begin
        cnt      <= cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load && s_tvalid) begin
      cmd_q <= cmd_e_t'(s_tdata[CMD_W-1:0]);
      elem  <= s_tdata[CMD_W +: ELEM_W];
    end
    if (dp_cmd.finish) begin
      out_status <= dp_cmd.status;
      out_count  <= COUNT_W'(cnt_next);
    end
  end

  // result item: status in the low bits, count above it
  assign m_tdata = {{(M_TDATA_W - STATUS_W - COUNT_W){1'b0}}, out_count, out_status};

  // status toward the controller
  assign dp_sts.cmd      = cmd_q;
  assign dp_sts.idx_end  = (idx_ext >= cnt);
  assign dp_sts.idx1_end = ((idx_ext + CW'(1)) >= cnt);
  assign dp_sts.full     = (cnt >= CW'(CAPACITY));
  assign dp_sts.match    = (ram_rdata == elem);
  assign dp_sts.out_free = !m_tvalid || m_tready;

endmodule
`default_nettype wire

// File: sv/bst_ctrl.sv
`default_nettype none
module bst_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire bst_pkg::dp_sts_t dp_sts,
  output bst_pkg::dp_cmd_t      dp_cmd
);
  import bst_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    SCAN_RD,
    SCAN_CMP,
    SHIFT_RD,
    SHIFT_WR,
    FINISH
  } state_t;

  state_t    state, state_next;
  status_e_t fin_status, fin_status_next;
  cnt_op_e_t fin_cnt_op, fin_cnt_op_next;
  logic      fin_wr, fin_wr_next;

  // next state and datapath commands
  always_comb begin
    state_next      = state;
    fin_status_next = fin_status;
    fin_cnt_op_next = fin_cnt_op;
    fin_wr_next     = fin_wr;
    dp_cmd          = '0;
    s_tready        = 1'b0;
    case (state)
      IDLE: begin
        s_tready    = 1'b1;
        dp_cmd.load = s_tvalid;
        if (s_tvalid) begin
          state_next = SCAN_RD;
        end
      end
      SCAN_RD: begin
        fin_status_next = ST_DONE;
        fin_cnt_op_next = CNT_HOLD;
        fin_wr_next     = 1'b0;
        case (dp_sts.cmd)
          CMD_INSERT: begin
            if (dp_sts.idx_end) begin
              state_next = FINISH;
              if (dp_sts.full) begin
                fin_status_next = ST_FULL;
              end else begin
                fin_cnt_op_next = CNT_INC;
                fin_wr_next     = 1'b1;
              end
            end else begin
              dp_cmd.rd_en = 1'b1;
              state_next   = SCAN_CMP;
            end
          end
          CMD_REMOVE: begin
            if (dp_sts.idx_end) begin
              fin_status_next = ST_NOT_FOUND;
              state_next      = FINISH;
            end else begin
              dp_cmd.rd_en = 1'b1;
              state_next   = SCAN_CMP;
            end
          end
          CMD_CLEAR: begin
            fin_cnt_op_next = CNT_CLR;
            state_next      = FINISH;
          end
          default: begin
            state_next = FINISH;
          end
        endcase
      end
      SCAN_CMP: begin
        if (dp_sts.match) begin
          if (dp_sts.cmd == CMD_INSERT) begin
            fin_status_next = ST_PRESENT;
            state_next      = FINISH;
          end else begin
            state_next = SHIFT_RD;
          end
        end else begin
          dp_cmd.idx_inc = 1'b1;
          state_next     = SCAN_RD;
        end
      end
      SHIFT_RD: begin
        if (dp_sts.idx1_end) begin
          fin_status_next = ST_DONE;
          fin_cnt_op_next = CNT_DEC;
          state_next      = FINISH;
        end else begin
          dp_cmd.rd_en   = 1'b1;
          dp_cmd.rd_next = 1'b1;
          state_next     = SHIFT_WR;
        end
      end
      SHIFT_WR: begin
        dp_cmd.shift_wr = 1'b1;
        dp_cmd.idx_inc  = 1'b1;
        state_next      = SHIFT_RD;
      end
      FINISH: begin
        dp_cmd.finish = dp_sts.out_free;
        dp_cmd.ins_wr = fin_wr;
        dp_cmd.cnt_op = fin_cnt_op;
        dp_cmd.status = fin_status;
        if (dp_sts.out_free) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // state and registered result decision
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      fin_status <= ST_DONE;
      fin_cnt_op <= CNT_HOLD;
      fin_wr     <= 1'b0;
    end else begin
      state      <= state_next;
      fin_status <= fin_status_next;
      fin_cnt_op <= fin_cnt_op_next;
      fin_wr     <= fin_wr_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/bounded_set_table.sv
`default_nettype none
// Set of up to CAPACITY signed 32-bit values kept packed in insertion order in a
// single-port-read RAM. One command per input item (insert, remove, clear, code 3
// does nothing) and one result item per command with a status and the member
// count after the step. Items are handled one at a time. An insert or remove
// scans the members from the first one, and every compare waits for the
// registered RAM read; a remove then moves each later member down one place,
// reading it and then writing it. Each item is accepted, scanned and shifted
// as its command needs, and its result loaded into the output register. The
// next item is accepted as soon as the previous result is in the output
// register, even if it is not yet taken. The table needs no clearing after
// reset.
module bounded_set_table #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [bst_pkg::S_TDATA_W-1:0] s_tdata,  // command[1:0], element[33:2]
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [bst_pkg::M_TDATA_W-1:0] m_tdata   // status[1:0], count[8:2]
);
  import bst_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer
  bst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .dp_sts   (dp_sts),
    .dp_cmd   (dp_cmd)
  );

  // table, count and result register
  bst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .dp_cmd   (dp_cmd),
    .dp_sts   (dp_sts)
  );

  // the result register is loaded only when it is empty or being emptied
  assert property (@(posedge clk) disable iff (rst)
    dp_cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken result");

  // an accepted item never finishes in the very next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !dp_cmd.finish)
    else $error("item finished without being decoded");

  // a full rejection reports a count equal to the capacity
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[STATUS_W-1:0] == ST_FULL))
      |-> (m_tdata[STATUS_W +: COUNT_W] == COUNT_W'(CAPACITY)))
    else $error("full status with a count below capacity");

  // the reported count never exceeds the capacity
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((CAPACITY > 127) ||
                  (m_tdata[STATUS_W +: COUNT_W] <= COUNT_W'(CAPACITY))))
    else $error("count above capacity");

endmodule
`default_nettype wire

// File: sim/tb_bounded_set_table.sv
module tb_bounded_set_table;
  timeunit 1ns;
  timeprecision 1ps;
  import bst_pkg::*;

  localparam int CAPACITY     = 64;
  // the drain wait is sized to cover a scan plus a full shift
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int MAX_REPORTS  = 30;

  typedef struct packed {
    cmd_e_t              cmd;
    logic [ELEM_W-1:0]   element;
  } set_cmd_t;

  typedef struct packed {
    status_e_t           status;
    logic [COUNT_W-1:0]  count;
  } set_reply_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  bounded_set_table #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // commands waiting to be driven, and the one on the bus
  set_cmd_t          command_q[$];
  set_cmd_t          offered_item;
  logic [ELEM_W-1:0] recent_elements[$];
  int                planned_total = 1;
  int                commands_offered = 0;
  int                commands_taken = 0;

  // shadow of the set and the replies it should produce
  logic [ELEM_W-1:0] set_members[$];
  set_reply_t        status_count_q[$];
  int                replies_checked = 0;
  int                errors = 0;
  int                n_stored = 0;
  int                n_removed = 0;
  int                n_dup = 0;
  int                n_missing = 0;
  int                n_full = 0;
  int                n_clear = 0;
  int                peak_size = 0;

  int                calm_left = 0;
  int                quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // next set state and reply for one command
  function automatic void apply_to_set(input cmd_e_t cmd, input logic [ELEM_W-1:0] element,
                                       output status_e_t status,
                                       output logic [COUNT_W-1:0] count);
    int hit;
    int n;
    hit = -1;
    foreach (set_members[i]) begin
      if (hit < 0 && set_members[i] == element) hit = i;
    end
    status = ST_DONE;
    case (cmd)
      CMD_INSERT: begin
        if (hit >= 0) begin
          status = ST_PRESENT;
          n_dup++;
        end else if (set_members.size() >= CAPACITY) begin
          status = ST_FULL;
          n_full++;
        end else begin
          set_members.push_back(element);
          n_stored++;
        end
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          status = ST_NOT_FOUND;
          n_missing++;
        end else begin
          // later members slide down one place, order kept
          set_members.delete(hit);
          n_removed++;
        end
      end
      CMD_CLEAR: begin
        set_members.delete();
        n_clear++;
      end
      default: ;
    endcase
    n = set_members.size();
    if (n > peak_size) peak_size = n;
    count = n[COUNT_W-1:0];
  endfunction

  function automatic logic [ELEM_W-1:0] corner_value(input int k);
    case (k)
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hffff_ffff;
      3:       return 32'h7fff_ffff;
      4:       return 32'h8000_0000;
      5:       return 32'h5555_5555;
      default: return 32'haaaa_aaaa;
    endcase
  endfunction

  // fresh values are almost never members; recent ones often are
  function automatic logic [ELEM_W-1:0] pick_element(input int fresh_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < fresh_pct || recent_elements.size() == 0) return $urandom;
    if (roll < fresh_pct + 10) return corner_value($urandom_range(0, 6));
    return recent_elements[$urandom_range(0, recent_elements.size() - 1)];
  endfunction

  task automatic queue_command(input cmd_e_t cmd, input logic [ELEM_W-1:0] element);
    set_cmd_t item;
    item.cmd = cmd;
    item.element = element;
    command_q.push_back(item);
    if (cmd == CMD_INSERT || cmd == CMD_REMOVE) begin
      recent_elements.push_back(element);
      if (recent_elements.size() > 160) void'(recent_elements.pop_front());
    end
  endtask

  function automatic int sender_idle_pct();
    int phase;
    phase = commands_offered * 4 / planned_total;
    if (calm_left > 0) return 0;
    if (phase == 1) return 59;
    if (phase >= 3) return 37;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    int phase;
    phase = commands_offered * 4 / planned_total;
    if (calm_left > 0) return 0;
    if (phase == 2) return 59;
    if (phase >= 3) return 37;
    return 0;
  endfunction

  // stimulus, reset and end of run
  initial begin : stimulus
    int random_start;
    int n;
    int kind;
    int insert_pct;
    int remove_pct;
    int misc_pct;
    int roll;
    logic [ELEM_W-1:0] first_fill;
    logic [ELEM_W-1:0] last_fill;
    logic [ELEM_W-1:0] value;

    // extremes, duplicates, misses, shifts from front, middle and back
    queue_command(CMD_INSERT, 32'h0000_0000);
    queue_command(CMD_INSERT, 32'h7fff_ffff);
    queue_command(CMD_INSERT, 32'h8000_0000);
    queue_command(CMD_INSERT, 32'hffff_ffff);
    queue_command(CMD_INSERT, 32'h7fff_ffff);
    queue_command(CMD_INSERT, 32'h0000_0001);
    queue_command(CMD_REMOVE, 32'h7fff_fffe);
    queue_command(CMD_REMOVE, 32'h8000_0000);
    queue_command(CMD_REMOVE, 32'h0000_0000);
    queue_command(CMD_REMOVE, 32'h0000_0001);
    queue_command(CMD_NOP,    32'hffff_ffff);
    queue_command(CMD_REMOVE, 32'h8000_0000);
    queue_command(CMD_CLEAR,  32'h1234_5678);
    queue_command(CMD_REMOVE, 32'h7fff_ffff);
    queue_command(CMD_CLEAR,  32'hffff_ffff);
    queue_command(CMD_INSERT, 32'hffff_ffff);
    queue_command(CMD_NOP,    32'h0000_0000);
    queue_command(CMD_CLEAR,  32'h0000_0000);

    // fill to capacity, then poke at the full table
    first_fill = $urandom;
    queue_command(CMD_INSERT, first_fill);
    for (int i = 1; i < CAPACITY - 1; i++) queue_command(CMD_INSERT, $urandom);
    last_fill = $urandom;
    queue_command(CMD_INSERT, last_fill);
    queue_command(CMD_INSERT, $urandom);
    queue_command(CMD_INSERT, first_fill);
    queue_command(CMD_INSERT, last_fill);
    queue_command(CMD_REMOVE, first_fill);
    queue_command(CMD_INSERT, 32'h7fff_ffff);
    queue_command(CMD_INSERT, 32'h8000_0000);
    queue_command(CMD_REMOVE, 32'h0000_0000);
    queue_command(CMD_REMOVE, last_fill);
    queue_command(CMD_NOP,    $urandom);
    queue_command(CMD_CLEAR,  $urandom);

    // random episodes: growth toward full, draining, churn and noise
    random_start = command_q.size();
    while (command_q.size() - random_start < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      n = $urandom_range(10, 60);
      misc_pct = 2;
      case (kind)
        0, 1, 2, 3: begin
          insert_pct = 85;
          remove_pct = 13;
          n = $urandom_range(30, 90);
        end
        4, 5: begin
          insert_pct = 25;
          remove_pct = 73;
        end
        6, 7: begin
          insert_pct = 50;
          remove_pct = 48;
        end
        8: begin
          insert_pct = 30;
          remove_pct = 30;
          misc_pct = 40;
          n = $urandom_range(5, 20);
        end
        default: begin
          queue_command(CMD_CLEAR, $urandom);
          insert_pct = 70;
          remove_pct = 28;
          n = $urandom_range(5, 30);
        end
      endcase
      for (int i = 0; i < n; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < misc_pct) begin
          queue_command(($urandom_range(0, 1) != 0) ? CMD_CLEAR : CMD_NOP, $urandom);
        end else if (roll < misc_pct + insert_pct) begin
          value = pick_element(70);
          queue_command(CMD_INSERT, value);
        end else begin
          value = pick_element(15);
          queue_command(CMD_REMOVE, value);
        end
      end
    end
    planned_total = command_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (commands_taken < planned_total) @(posedge clk);
    while (status_count_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands, %0d replies checked, %0d mismatches, peak size %0d of %0d",
             commands_taken, replies_checked, errors, peak_size, CAPACITY);
    $display("inserted %0d, removed %0d, duplicate %0d, miss %0d, full %0d, clear %0d",
             n_stored, n_removed, n_dup, n_missing, n_full, n_clear);
    if (errors == 0 && status_count_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // driver: offer the next command and move tready, on the falling edge
  always @(negedge clk) begin : driver
    logic                 next_valid;
    logic [S_TDATA_W-1:0] next_data;
    set_cmd_t             item;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 63) == 0) calm_left = $urandom_range(10, 40);
      next_valid = (commands_offered != commands_taken);
      next_data = s_tdata;
      if (!next_valid && command_q.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct()) begin
        item = command_q.pop_front();
        offered_item = item;
        next_data = '0;
        next_data[CMD_W-1:0] = item.cmd;
        next_data[CMD_W +: ELEM_W] = item.element;
        next_valid = 1'b1;
        commands_offered++;
      end
      s_tvalid <= next_valid;
      s_tdata <= next_data;
      m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  // monitor: predict on each accepted command, check each accepted reply
  always @(posedge clk) begin : monitor
    set_reply_t         want;
    status_e_t          want_status;
    logic [COUNT_W-1:0] want_count;
    status_e_t          got_status;
    logic [COUNT_W-1:0] got_count;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        apply_to_set(offered_item.cmd, offered_item.element, want_status, want_count);
        want.status = want_status;
        want.count = want_count;
        status_count_q.push_back(want);
        commands_taken++;
      end
      if (m_tvalid && m_tready) begin
        got_status = status_e_t'(m_tdata[STATUS_W-1:0]);
        got_count = m_tdata[STATUS_W +: COUNT_W];
        if (status_count_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: reply with none pending, got status %0d count %0d",
                     $time, got_status, got_count);
        end else begin
          want = status_count_q.pop_front();
          replies_checked++;
          if (got_status != want.status) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: status expected %0d got %0d", $time, want.status, got_status);
          end
          if (got_count != want.count) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: count expected %0d got %0d", $time, want.count, got_count);
          end
        end
      end
    end
  end

  // watchdog on cycles where no item moves on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
